// ===== rtl/core/pcd_pkg.sv =====
// shared constants, types and code tables of the pn component delay correlator
package pcd_pkg;

    localparam int DEFAULT_CODE_LENGTH  = 7;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;
    localparam int DEFAULT_SUM_WIDTH    = 40;
    localparam int MAX_CODE_LENGTH      = 64;

    localparam int WINDOW_WIDTH = 16;
    localparam int STATUS_WIDTH = 2;
    localparam int DELAY_WIDTH  = 3;

    typedef logic [WINDOW_WIDTH-1:0] t_window;
    typedef logic [STATUS_WIDTH-1:0] t_status;
    typedef logic [DELAY_WIDTH-1:0]  t_delay;

    localparam t_window WINDOW_RESET = 16'd2310;

    localparam t_status STATUS_RUNNING = 2'd0;
    localparam t_status STATUS_FOUND   = 2'd1;
    localparam t_status STATUS_NONE    = 2'd2;

    // base code + + + - - + -, a set bit marks a minus chip
    localparam int              BASE_CODE_LEN = 7;
    localparam logic [6:0]      BASE_CODE_NEG = 7'b1011000;

    // minus-chip flags for code positions 0 .. len-1, the base code repeating
    function automatic logic [MAX_CODE_LENGTH-1:0] chip_pattern(input int len);
        logic [MAX_CODE_LENGTH-1:0] pat;
        pat = '0;
        for (int p = 0; p < MAX_CODE_LENGTH; p++) begin
            if (p < len) begin
                pat[p] = BASE_CODE_NEG[p % BASE_CODE_LEN];
            end
        end
        return pat;
    endfunction

endpackage

// ===== rtl/core/pcd_if.sv =====
// stream interfaces of the pn component delay correlator

interface pcd_sample_if #(
    parameter int SAMPLE_WIDTH = pcd_pkg::DEFAULT_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pcd_result_if;
    logic             valid;
    logic             ready;
    pcd_pkg::t_status status;
    pcd_pkg::t_delay  delay_index;

    modport source (output valid, output status, output delay_index, input ready);
    modport sink   (input valid, input status, input delay_index, output ready);
endinterface

interface pcd_cfg_if;
    logic             valid;
    logic             ready;
    pcd_pkg::t_window window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

// ===== rtl/core/pn_component_delay_correlator.sv =====
// pn component delay correlator: windowed correlation against all code shifts
//
// Each received sample is added to, or subtracted from, one running sum per
// cyclic shift of the plus/minus-one component code (+ + + - - + -, repeated
// for longer codes). A window closes after window_length samples (a length
// of zero acts as one, and a length written below the count already reached
// closes the window on the next sample). Every sample yields exactly one
// result: status 0 while the window runs, 1 with the first positive delay in
// ascending order, or 2 when no sum is positive; the sums clear at each
// window end and the code phase keeps turning across windows. The block
// takes one sample per clock cycle while the output register is free or
// being emptied; a sample is registered in the input register on
// acceptance, and its result is written into the output register once
// that register is free or emptying. The work per sample is the parallel
// add into every delay sum followed by a priority pick among the updated
// sums.
module pn_component_delay_correlator #(
    parameter int CODE_LENGTH  = pcd_pkg::DEFAULT_CODE_LENGTH,
    parameter int SAMPLE_WIDTH = pcd_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int SUM_WIDTH    = pcd_pkg::DEFAULT_SUM_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pcd_cfg_if.sink              i_cfg,
    pcd_sample_if.sink           i_sample,
    pcd_result_if.source         o_result
);

    // chip signs at reset, phase zero
    localparam logic [pcd_pkg::MAX_CODE_LENGTH-1:0] CHIP_ALL =
        pcd_pkg::chip_pattern(CODE_LENGTH);
    localparam logic [CODE_LENGTH-1:0] CHIP_RESET = CHIP_ALL[CODE_LENGTH-1:0];

    // configuration
    pcd_pkg::t_window r_wlen;

    // input register stage
    logic                           r_s1_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_sample;

    // correlator state: bit d of r_chips is the minus flag of delay d's chip
    logic [CODE_LENGTH-1:0]         r_chips;
    pcd_pkg::t_window               r_count;
    logic signed [SUM_WIDTH-1:0]    r_sums [CODE_LENGTH];

    // output register
    logic             r_out_valid;
    pcd_pkg::t_status r_out_status;
    pcd_pkg::t_delay  r_out_delay;

    // combinational next values
    logic                        s1_adv;
    logic signed [SUM_WIDTH-1:0] sample_ext;
    logic signed [SUM_WIDTH-1:0] n_sums [CODE_LENGTH];
    pcd_pkg::t_window            count_inc;
    pcd_pkg::t_window            len_eff;
    logic                        win_end;
    logic                        found;
    pcd_pkg::t_delay             found_idx;
    pcd_pkg::t_status            n_status;
    pcd_pkg::t_delay             n_delay;

    // the working stage moves on when the output register is free or emptying
    assign s1_adv         = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_s1_valid || s1_adv;
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.delay_index = r_out_delay;

    always_comb begin
        // sign extension or wrap of the sample to sum width
        sample_ext = SUM_WIDTH'(r_s1_sample);
        for (int d = 0; d < CODE_LENGTH; d++) begin
            n_sums[d] = r_chips[d] ? (r_sums[d] - sample_ext)
                                   : (r_sums[d] + sample_ext);
        end

        count_inc = r_count + pcd_pkg::t_window'(1);
        len_eff   = (r_wlen == '0) ? pcd_pkg::t_window'(1) : r_wlen;
        // wrap of the count past its top also closes the window
        win_end   = (count_inc >= len_eff) || (count_inc == '0);

        // first strictly positive sum, lowest delay wins
        found     = 1'b0;
        found_idx = '0;
        for (int d = CODE_LENGTH - 1; d >= 0; d--) begin
            if (!n_sums[d][SUM_WIDTH-1] && (n_sums[d] != '0)) begin
                found     = 1'b1;
                found_idx = pcd_pkg::t_delay'(d);
            end
        end

        if (!win_end) begin
            n_status = pcd_pkg::STATUS_RUNNING;
            n_delay  = '0;
        end else if (found) begin
            n_status = pcd_pkg::STATUS_FOUND;
            n_delay  = found_idx;
        end else begin
            n_status = pcd_pkg::STATUS_NONE;
            n_delay  = '0;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= pcd_pkg::WINDOW_RESET;
        end else if (i_cfg.valid) begin
            r_wlen <= i_cfg.window_length;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample.valid && i_sample.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_s1_sample <= i_sample.sample;
        end
    end

    // correlator state: sums, window count and rotating chip signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chips <= CHIP_RESET;
            r_count <= '0;
            for (int d = 0; d < CODE_LENGTH; d++) begin
                r_sums[d] <= '0;
            end
        end else if (s1_adv) begin
            // advancing the phase shifts every delay one position along
            r_chips <= {r_chips[0], r_chips[CODE_LENGTH-1:1]};
            r_count <= win_end ? '0 : count_inc;
            for (int d = 0; d < CODE_LENGTH; d++) begin
                r_sums[d] <= win_end ? '0 : n_sums[d];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= n_status;
            r_out_delay  <= n_delay;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench for the pn component delay correlator: directed and random sample streams
module tb;
    import pcd_pkg::*;

    localparam int CODE_LEN     = DEFAULT_CODE_LENGTH;
    localparam int SMP_W        = DEFAULT_SAMPLE_WIDTH;
    localparam int SUM_W        = DEFAULT_SUM_WIDTH;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;
    localparam int STEADY_PHASE = 3;

    typedef logic signed [SMP_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0] corr_sum_t;

    // one result transaction as the block reports it
    typedef struct packed {
        t_status status;
        t_delay  delay_index;
    } decision_t;

    // shapes of random window content
    typedef enum int {
        PAT_ALIGNED,
        PAT_INVERTED,
        PAT_NEGATIVE,
        PAT_NOISE,
        PAT_FULL_SCALE
    } pattern_e;

    // component code + + + - - + -
    localparam int CODE_CHIP [CODE_LEN] = '{1, 1, 1, -1, -1, 1, -1};

    logic i_clk;
    logic i_rst_n;

    pcd_sample_if #(.SAMPLE_WIDTH(SMP_W)) smp_if ();
    pcd_result_if                         res_if ();
    pcd_cfg_if                            cfg_if ();

    pn_component_delay_correlator #(
        .CODE_LENGTH  (CODE_LEN),
        .SAMPLE_WIDTH (SMP_W),
        .SUM_WIDTH    (SUM_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_sample (smp_if),
        .o_result (res_if)
    );

    // samples waiting to be offered, decisions waiting to be seen
    sample_t     sample_backlog [$];
    decision_t   expected_decisions [$];
    int unsigned queued_total;
    int unsigned result_count;
    int unsigned error_count;
    int unsigned cycle_count;
    bit          steady_flow;

    // own copy of the correlator state
    corr_sum_t   corr_sums [CODE_LEN];
    int unsigned corr_phase;
    t_window     win_count;
    t_window     win_len;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch at result %0d: %s", result_count, what);
        end
        error_count++;
    endtask

    // one accepted sample: update every delay sum, then decide at a window end
    function automatic void correlate_sample(input sample_t smp);
        corr_sum_t   term;
        int unsigned eff_len;
        t_window     next_count;
        decision_t   dec;
        term = smp;
        for (int d = 0; d < CODE_LEN; d++) begin
            if (CODE_CHIP[(corr_phase + d) % CODE_LEN] > 0) begin
                corr_sums[d] = corr_sums[d] + term;
            end else begin
                corr_sums[d] = corr_sums[d] - term;
            end
        end
        // phase turns on every sample, the deciding one too
        corr_phase = (corr_phase + 1) % CODE_LEN;
        next_count = win_count + 1'b1;
        // a zero length behaves as one
        eff_len = (win_len == '0) ? 1 : win_len;
        dec.status      = STATUS_RUNNING;
        dec.delay_index = '0;
        // >= so that a length lowered below the count closes at once
        if (next_count >= eff_len || next_count == '0) begin
            dec.status = STATUS_NONE;
            for (int d = 0; d < CODE_LEN; d++) begin
                if (dec.status == STATUS_NONE && corr_sums[d] > 0) begin
                    dec.status      = STATUS_FOUND;
                    dec.delay_index = t_delay'(d);
                end
            end
            for (int d = 0; d < CODE_LEN; d++) begin
                corr_sums[d] = '0;
            end
            win_count = '0;
        end else begin
            win_count = next_count;
        end
        expected_decisions.push_back(dec);
    endfunction

    // sample driver: idles at random unless the steady stretch is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid  <= 1'b0;
            smp_if.sample <= '0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                correlate_sample(smp_if.sample);
            end
            if (!smp_if.valid || smp_if.ready) begin
                if (sample_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= 17)) begin
                    smp_if.valid  <= 1'b1;
                    smp_if.sample <= sample_backlog.pop_front();
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each transaction against the oldest expected decision
    always @(posedge i_clk) begin
        decision_t want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_decisions.size() == 0) begin
                    report_mismatch("result with no sample behind it");
                end else begin
                    want = expected_decisions.pop_front();
                    if (res_if.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  res_if.status, want.status));
                    end
                    if (res_if.delay_index !== want.delay_index) begin
                        report_mismatch($sformatf("delay_index got %0d want %0d",
                                                  res_if.delay_index, want.delay_index));
                    end
                end
                result_count++;
            end
            res_if.ready <= steady_flow || $urandom_range(99) >= 17;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic push_sample(input sample_t smp);
        sample_backlog.push_back(smp);
        queued_total++;
    endtask

    // wait until every sample is taken and every decision has come back
    task automatic drain();
        while (sample_backlog.size() != 0 || smp_if.valid || expected_decisions.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // register write; only called with the block idle
    task automatic write_window(input t_window len);
        @(posedge i_clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.window_length <= len;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        win_len = len;
    endtask

    // one window of shaped content; the code position follows the queued count
    task automatic queue_window(input int len);
        int       eff;
        int       pick;
        int       target;
        int       amp;
        int       val;
        int       chip;
        pattern_e pat;
        eff    = (len == 0) ? 1 : len;
        pick   = $urandom_range(99);
        target = $urandom_range(CODE_LEN - 1);
        amp    = $urandom_range(24000, 1);
        if (pick < 55) begin
            pat = PAT_ALIGNED;
        end else if (pick < 65) begin
            pat = PAT_INVERTED;
        end else if (pick < 75) begin
            pat = PAT_NEGATIVE;
        end else if (pick < 90) begin
            pat = PAT_NOISE;
        end else begin
            pat = PAT_FULL_SCALE;
        end
        for (int i = 0; i < eff; i++) begin
            chip = CODE_CHIP[(queued_total + target) % CODE_LEN];
            case (pat)
                PAT_ALIGNED: begin
                    val = chip * amp + int'($urandom_range(amp / 2)) - amp / 4;
                end
                PAT_INVERTED: begin
                    val = -(chip * amp) + int'($urandom_range(amp / 2)) - amp / 4;
                end
                PAT_NEGATIVE: begin
                    val = -int'($urandom_range(32768, 1));
                end
                PAT_FULL_SCALE: begin
                    val = (chip > 0) ? 32767 : -32768;
                end
                default: begin
                    val = int'(sample_t'($urandom));
                end
            endcase
            push_sample(sample_t'(val));
        end
    endtask

    initial begin
        int unsigned random_items;
        int          len;
        int          windows;
        int          phase_no;

        i_rst_n              <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.window_length <= '0;
        steady_flow          = 1'b0;
        queued_total         = 0;
        result_count         = 0;
        error_count          = 0;
        corr_phase           = 0;
        win_count            = '0;
        win_len              = WINDOW_RESET;
        foreach (corr_sums[d]) begin
            corr_sums[d] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default window: sample extremes, all still running
        push_sample(sample_t'(32767));
        push_sample(sample_t'(-32768));
        push_sample(sample_t'(0));
        push_sample(sample_t'(-1));
        push_sample(sample_t'(1));
        drain();

        // length lowered below the count reached: next sample closes the window
        write_window(t_window'(3));
        push_sample(sample_t'(1000));
        push_sample(sample_t'(-2000));
        push_sample(sample_t'(3000));
        push_sample(sample_t'(-4000));
        drain();

        // zero length: every sample closes a window, zero gives no positive sum
        write_window('0);
        push_sample(sample_t'(32767));
        push_sample(sample_t'(-32768));
        push_sample(sample_t'(0));
        push_sample(sample_t'(1));
        drain();

        // longest window, then cut short part way
        write_window(16'hFFFF);
        push_sample(sample_t'(-32768));
        push_sample(sample_t'(-32768));
        push_sample(sample_t'(32767));
        push_sample(sample_t'(5));
        drain();
        write_window(t_window'(2));
        push_sample(sample_t'(-7));
        push_sample(sample_t'(12));
        push_sample(sample_t'(-12));
        drain();

        // single-sample windows
        write_window(t_window'(1));
        push_sample(sample_t'(-1));
        push_sample(sample_t'(0));

        // random phases, each with a length of its own, separated by a full drain
        random_items = 0;
        phase_no     = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            if (steady_flow) begin
                @(posedge i_clk);
                steady_flow = 1'b0;
            end
            case ($urandom_range(9))
                0:       len = 0;
                1:       len = 1;
                2:       len = 7;
                3:       len = 14;
                4:       len = 21;
                7:       len = 35;
                8:       len = 3;
                9:       len = $urandom_range(120, 41);
                default: len = $urandom_range(40, 2);
            endcase
            windows = $urandom_range(6, 2);
            if (phase_no == STEADY_PHASE) begin
                // long stretch with both sides always willing
                len     = 7;
                windows = 25;
            end
            write_window(t_window'(len));
            if (phase_no == STEADY_PHASE) begin
                steady_flow = 1'b1;
            end
            if (((len == 0) ? 1 : len) * windows > 200) begin
                windows = 1;
            end
            for (int w = 0; w < windows; w++) begin
                queue_window(len);
                random_items += (len == 0) ? 1 : len;
            end
            phase_no++;
        end

        drain();
        steady_flow = 1'b0;
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_decisions.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== pn_component_delay_correlator.f =====
rtl/core/pcd_pkg.sv
rtl/core/pcd_if.sv
rtl/core/pn_component_delay_correlator.sv
verif/tb.sv
